>>> rtl/core/assert_macros.svh
// assertion macros used by the top level of the passage direction detector
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising clock edge out of reset
`define TBP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TBP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TBP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define TBP_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/tbpdd_pkg.sv
// package of the passage direction detector: mode and event codes, register
// indexes, fixed field widths and the poll interval table; no dependencies
package tbpdd_pkg;

    // fixed field widths
    localparam int LIMIT_W   = 13;
    localparam int PCT_W     = 7;
    localparam int TMO_W     = 16;
    localparam int STEP_W    = 10;
    localparam int ELAPSED_W = 17;
    localparam int POLL_W    = 13;
    localparam int MODE_W    = 3;
    localparam int EVENT_W   = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DETECT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ENTRY  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EXIT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DONE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MOTION = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CAL    = 3'd6;

    // reported events
    localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
    localparam logic [EVENT_W-1:0] EV_ENTRANCE    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_EXIT        = 3'd2;
    localparam logic [EVENT_W-1:0] EV_DOOR_OPEN   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_DOOR_CLOSED = 3'd4;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT     = 3'd5;
    localparam logic [EVENT_W-1:0] EV_CAL_DONE    = 3'd6;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_LIMIT   = 3'd0;
    localparam logic [2:0] REG_PCT     = 3'd1;
    localparam logic [2:0] REG_SWAP    = 3'd2;
    localparam logic [2:0] REG_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_STEP    = 3'd4;

    // reset values
    localparam int LIMIT_RESET   = 900;
    localparam int PCT_RESET     = 30;
    localparam int TIMEOUT_RESET = 3000;
    localparam int STEP_RESET    = 20;
    localparam int BASE_RESET    = 1000;
    localparam int TOL_RESET     = 10;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // wait before the next poll, per mode
    function automatic logic [POLL_W-1:0] poll_for_mode(input logic [MODE_W-1:0] mode);
        logic [POLL_W-1:0] poll;
        case (mode)
            MODE_IDLE:   poll = 13'd5000;
            MODE_DETECT: poll = 13'd50;
            MODE_MOTION: poll = 13'd200;
            MODE_CAL:    poll = 13'd200;
            default:     poll = 13'd20;
        endcase
        return poll;
    endfunction

endpackage

>>> rtl/core/tbpdd_cal.sv
// calibration arithmetic: baseline means, clamp and tolerance, four stages
// depends on tbpdd_pkg; divisions by constants use reciprocal multiplies
module tbpdd_cal
    import tbpdd_pkg::*;
#(
    parameter int CAL_SAMPLES = 20,
    parameter int DIST_BITS   = 13,
    localparam int SUM_W = $clog2(CAL_SAMPLES * ((1 << DIST_BITS) - 1) + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SUM_W-1:0]     i_sum_near,
    input  logic [SUM_W-1:0]     i_sum_far,
    input  logic [LIMIT_W-1:0]   i_limit,
    input  logic [PCT_W-1:0]     i_pct,
    output logic                 o_done,
    output logic [DIST_BITS-1:0] o_base_near,
    output logic [DIST_BITS-1:0] o_base_far,
    output logic [DIST_BITS-1:0] o_tol
);

    // floor(x / CAL_SAMPLES) = (x * RECIP_N) >> SHIFT_N for every x below 2^SUM_W
    localparam int SHIFT_N = SUM_W + $clog2(CAL_SAMPLES);
    localparam int RN_W    = SUM_W + 1;
    localparam longint unsigned RECIP_N_L =
        ((64'd1 << SHIFT_N) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [RN_W-1:0] RECIP_N = RN_W'(RECIP_N_L);
    localparam int PN_W = SUM_W + RN_W;

    // floor(y / 100) the same way, y = mean * percent
    localparam int MP_W      = DIST_BITS + PCT_W;
    localparam int SHIFT_H   = MP_W + 7;
    localparam int RH_W      = MP_W + 1;
    localparam longint unsigned RECIP_H_L = ((64'd1 << SHIFT_H) + 64'd99) / 64'd100;
    localparam logic [RH_W-1:0] RECIP_H = RH_W'(RECIP_H_L);
    localparam int PH_W = MP_W + RH_W;
    localparam int CMP_W = (DIST_BITS > LIMIT_W) ? DIST_BITS : LIMIT_W;

    logic [3:0]           r_vld;
    logic [PN_W-1:0]      r_prod_near;
    logic [PN_W-1:0]      r_prod_far;
    logic [DIST_BITS-1:0] r_base_near;
    logic [DIST_BITS-1:0] r_base_far;
    logic [DIST_BITS-1:0] r_mean;
    logic [MP_W-1:0]      r_mp;
    logic [DIST_BITS-1:0] r_tol;

    logic [DIST_BITS-1:0] n_avg_near;
    logic [DIST_BITS-1:0] n_avg_far;
    logic [DIST_BITS-1:0] n_base_near;
    logic [DIST_BITS-1:0] n_base_far;
    logic [DIST_BITS:0]   n_base_sum;
    logic [PH_W-1:0]      n_prod_h;
    logic [DIST_BITS:0]   n_tol_wide;
    logic [DIST_BITS-1:0] n_tol;

    always_comb begin
        n_avg_near = r_prod_near[SHIFT_N +: DIST_BITS];
        n_avg_far  = r_prod_far[SHIFT_N +: DIST_BITS];
        // clamp to the configured limit
        n_base_near = (CMP_W'(n_avg_near) > CMP_W'(i_limit)) ?
                      DIST_BITS'(i_limit) : n_avg_near;
        n_base_far  = (CMP_W'(n_avg_far) > CMP_W'(i_limit)) ?
                      DIST_BITS'(i_limit) : n_avg_far;
        n_base_sum  = {1'b0, n_base_near} + {1'b0, n_base_far};
        n_prod_h    = PH_W'(r_mp) * PH_W'(RECIP_H);
        n_tol_wide  = n_prod_h[SHIFT_H +: DIST_BITS + 1];
        // percent above 100 can push the tolerance past the distance range
        n_tol       = n_tol_wide[DIST_BITS] ? '1 : n_tol_wide[DIST_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
        r_prod_near <= PN_W'(i_sum_near) * PN_W'(RECIP_N);
        r_prod_far  <= PN_W'(i_sum_far) * PN_W'(RECIP_N);
        r_base_near <= n_base_near;
        r_base_far  <= n_base_far;
        r_mean      <= n_base_sum[DIST_BITS:1];
        r_mp        <= MP_W'(r_mean) * MP_W'(i_pct);
        r_tol       <= n_tol;
    end

    assign o_done      = r_vld[3];
    assign o_base_near = r_base_near;
    assign o_base_far  = r_base_far;
    assign o_tol       = r_tol;

endmodule

>>> rtl/core/two_beam_passage_direction_detector.sv
// top level of the two-beam passage direction detector
// depends on tbpdd_pkg, tbpdd_cal and assert_macros.svh
//
// usage
//   input channel (i_valid / o_ready): one poll per transfer, two beam
//   distances, a door-closed flag and a motion flag
//   output channel (o_valid / i_ready): exactly one result per poll, in order:
//   mode, event, passage time, indicator, next poll interval, tolerance
//   config: apb-style write port, registers at byte address 4*i; pready tied high
//   path: a poll lands in an input register, its result is then registered in
//   the output register, and o_valid comes from that register
//   throughput: one poll per cycle while the output register is free; the poll
//   that closes calibration runs the four-stage calibration unit and the input
//   waits for it until the calibration result is loaded into the output register
//   reset: calibration mode, baselines 1000, tolerance 10, registers at
//   their defaults, both channels empty
//   stall: a held result stays in the output register; one more poll is
//   taken into the input register, then o_ready drops until i_ready returns
`include "assert_macros.svh"

module two_beam_passage_direction_detector
    import tbpdd_pkg::*;
#(
    parameter int CAL_SAMPLES = 20,
    parameter int DIST_BITS   = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // poll input
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [DIST_BITS-1:0] i_near_distance,
    input  logic [DIST_BITS-1:0] i_far_distance,
    input  logic                 i_door_closed,
    input  logic                 i_motion_seen,
    // result output
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MODE_W-1:0]    o_mode_now,
    output logic [EVENT_W-1:0]   o_event_code,
    output logic [ELAPSED_W-1:0] o_passage_ms,
    output logic                 o_indicator_on,
    output logic [POLL_W-1:0]    o_poll_interval_ms,
    output logic [DIST_BITS-1:0] o_threshold_tolerance,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    localparam int SUM_W = $clog2(CAL_SAMPLES * ((1 << DIST_BITS) - 1) + 1);
    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

    // sequencer: normal polls, calibration math in flight, calibration result out
    typedef enum logic [1:0] {
        SEQ_RUN,
        SEQ_CAL,
        SEQ_EMIT
    } t_seq_e;

    t_seq_e r_seq;

    // configuration registers
    logic [LIMIT_W-1:0] r_cfg_limit;
    logic [PCT_W-1:0]   r_cfg_pct;
    logic               r_cfg_swap;
    logic [TMO_W-1:0]   r_cfg_timeout;
    logic [STEP_W-1:0]  r_cfg_step;

    // input register
    logic                 r_in_valid;
    logic [DIST_BITS-1:0] r_near;
    logic [DIST_BITS-1:0] r_far;
    logic                 r_door;
    logic                 r_motion;

    // detector state
    logic [MODE_W-1:0]    r_mode;
    logic [DIST_BITS-1:0] r_base_near;
    logic [DIST_BITS-1:0] r_base_far;
    logic [DIST_BITS-1:0] r_tol;
    logic [CNT_W-1:0]     r_count;
    logic [SUM_W-1:0]     r_sum_near;
    logic [SUM_W-1:0]     r_sum_far;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic                 r_cal_start;

    // output register
    logic                 r_out_valid;
    logic [MODE_W-1:0]    r_out_mode;
    logic [EVENT_W-1:0]   r_out_event;
    logic [ELAPSED_W-1:0] r_out_passage;
    logic                 r_out_ind;
    logic [POLL_W-1:0]    r_out_poll;
    logic [DIST_BITS-1:0] r_out_tol;

    // next-state values of one poll
    logic [MODE_W-1:0]    n_mode;
    logic [EVENT_W-1:0]   n_event;
    logic [ELAPSED_W-1:0] n_passage;
    logic [ELAPSED_W-1:0] n_elapsed;
    logic [CNT_W-1:0]     n_count;
    logic [SUM_W-1:0]     n_sum_near;
    logic [SUM_W-1:0]     n_sum_far;
    logic                 n_cal_fin;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_consume;
    logic                 w_emit;
    logic                 w_out_load;
    logic                 w_cfg_wr;
    logic [2:0]           w_cfg_idx;
    logic [MODE_W-1:0]    w_mode_pre;
    logic                 w_near_hit;
    logic                 w_far_hit;
    logic                 w_near_clear;
    logic                 w_far_clear;
    logic [ELAPSED_W:0]   w_timer_sum;
    logic [ELAPSED_W-1:0] w_timer;
    logic                 w_pass_hit;
    logic [MODE_W-1:0]    w_res_mode;
    logic [EVENT_W-1:0]   w_res_event;
    logic [ELAPSED_W-1:0] w_res_passage;

    logic                 w_cal_done;
    logic [DIST_BITS-1:0] w_cal_near;
    logic [DIST_BITS-1:0] w_cal_far;
    logic [DIST_BITS-1:0] w_cal_tol;

    // handshakes
    assign w_out_free = !r_out_valid || i_ready;
    assign w_consume  = r_in_valid && (r_seq == SEQ_RUN) && w_out_free;
    assign w_emit     = (r_seq == SEQ_EMIT) && w_out_free;
    assign o_ready    = !r_in_valid || w_consume;
    assign w_accept   = i_valid && o_ready;
    assign w_out_load = (w_consume && !n_cal_fin) || w_emit;

    // config port
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (w_cfg_idx)
            REG_LIMIT:   prdata = DATA_W'(r_cfg_limit);
            REG_PCT:     prdata = DATA_W'(r_cfg_pct);
            REG_SWAP:    prdata = DATA_W'(r_cfg_swap);
            REG_TIMEOUT: prdata = DATA_W'(r_cfg_timeout);
            REG_STEP:    prdata = DATA_W'(r_cfg_step);
            default:     prdata = '0;
        endcase
    end

    // beam compares: distance < baseline - tolerance, written without signs
    assign w_near_hit   = ({1'b0, r_near} + {1'b0, r_tol}) < {1'b0, r_base_near};
    assign w_far_hit    = ({1'b0, r_far} + {1'b0, r_tol}) < {1'b0, r_base_far};
    assign w_near_clear = ({1'b0, r_near} + {1'b0, r_tol}) > {1'b0, r_base_near};
    assign w_far_clear  = ({1'b0, r_far} + {1'b0, r_tol}) > {1'b0, r_base_far};

    // confirmation timer, saturating
    assign w_timer_sum = {1'b0, r_elapsed} + (ELAPSED_W + 1)'(r_cfg_step);
    assign w_timer     = w_timer_sum[ELAPSED_W] ? ELAPSED_MAX : w_timer_sum[ELAPSED_W-1:0];

    // mode logic for the poll in the input register
    always_comb begin
        w_mode_pre = r_mode;
        n_event    = EV_NONE;
        n_passage  = '0;
        n_elapsed  = r_elapsed;
        n_count    = r_count;
        n_sum_near = r_sum_near;
        n_sum_far  = r_sum_far;
        n_cal_fin  = 1'b0;
        w_pass_hit = 1'b0;

        // closed door wins over everything outside idle
        if (r_mode != MODE_IDLE && r_door) begin
            w_mode_pre = MODE_IDLE;
            n_event    = EV_DOOR_CLOSED;
        end
        n_mode = w_mode_pre;

        case (w_mode_pre)
            MODE_CAL: begin
                if (r_count < CNT_W'(CAL_SAMPLES)) begin
                    n_sum_near = r_sum_near + SUM_W'(r_near);
                    n_sum_far  = r_sum_far + SUM_W'(r_far);
                    n_count    = r_count + CNT_W'(1);
                    if (n_count == CNT_W'(CAL_SAMPLES)) begin
                        n_cal_fin = 1'b1;
                        n_mode    = MODE_IDLE;
                        n_event   = EV_CAL_DONE;
                    end
                end
            end
            MODE_IDLE: begin
                if (!r_door) begin
                    n_mode  = MODE_MOTION;
                    n_event = EV_DOOR_OPEN;
                end
            end
            MODE_MOTION: begin
                if (r_motion) begin
                    n_mode = MODE_DETECT;
                end
            end
            MODE_DETECT: begin
                if (!r_motion) begin
                    n_mode = MODE_MOTION;
                end else if (w_near_hit) begin
                    n_mode    = MODE_ENTRY;
                    n_elapsed = '0;
                end else if (w_far_hit) begin
                    n_mode    = MODE_EXIT;
                    n_elapsed = '0;
                end
            end
            MODE_ENTRY, MODE_EXIT: begin
                n_elapsed  = w_timer;
                // the other beam confirms the direction
                w_pass_hit = (w_mode_pre == MODE_ENTRY) ? w_far_hit : w_near_hit;
                if (w_pass_hit) begin
                    n_event   = ((w_mode_pre == MODE_ENTRY) != r_cfg_swap) ?
                                EV_ENTRANCE : EV_EXIT;
                    n_passage = w_timer;
                    n_mode    = MODE_DONE;
                end else if (w_timer >= ELAPSED_W'(r_cfg_timeout)) begin
                    n_event = EV_TIMEOUT;
                    n_mode  = MODE_DONE;
                end
            end
            MODE_DONE: begin
                // wait until both beams are clear again
                if (w_near_clear && w_far_clear) begin
                    n_mode = MODE_MOTION;
                end
            end
            default: begin
            end
        endcase
    end

    // result source: a normal poll or the delayed calibration result
    always_comb begin
        if (r_seq == SEQ_EMIT) begin
            w_res_mode    = MODE_IDLE;
            w_res_event   = EV_CAL_DONE;
            w_res_passage = '0;
        end else begin
            w_res_mode    = n_mode;
            w_res_event   = n_event;
            w_res_passage = n_passage;
        end
    end

    tbpdd_cal #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .DIST_BITS   (DIST_BITS)
    ) u_cal (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_cal_start),
        .i_sum_near  (r_sum_near),
        .i_sum_far   (r_sum_far),
        .i_limit     (r_cfg_limit),
        .i_pct       (r_cfg_pct),
        .o_done      (w_cal_done),
        .o_base_near (w_cal_near),
        .o_base_far  (w_cal_far),
        .o_tol       (w_cal_tol)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq         <= SEQ_RUN;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cal_start   <= 1'b0;
            r_mode        <= MODE_CAL;
            r_base_near   <= DIST_BITS'(BASE_RESET);
            r_base_far    <= DIST_BITS'(BASE_RESET);
            r_tol         <= DIST_BITS'(TOL_RESET);
            r_count       <= '0;
            r_sum_near    <= '0;
            r_sum_far     <= '0;
            r_elapsed     <= '0;
            r_cfg_limit   <= LIMIT_W'(LIMIT_RESET);
            r_cfg_pct     <= PCT_W'(PCT_RESET);
            r_cfg_swap    <= 1'b0;
            r_cfg_timeout <= TMO_W'(TIMEOUT_RESET);
            r_cfg_step    <= STEP_W'(STEP_RESET);
        end else begin
            // register writes
            if (w_cfg_wr) begin
                case (w_cfg_idx)
                    REG_LIMIT:   r_cfg_limit   <= pwdata[LIMIT_W-1:0];
                    REG_PCT:     r_cfg_pct     <= pwdata[PCT_W-1:0];
                    REG_SWAP:    r_cfg_swap    <= pwdata[0];
                    REG_TIMEOUT: r_cfg_timeout <= pwdata[TMO_W-1:0];
                    REG_STEP:    r_cfg_step    <= pwdata[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end

            // input register fill and drain
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_consume) begin
                r_in_valid <= 1'b0;
            end

            // output register
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            // one-cycle start pulse for the calibration unit
            r_cal_start <= w_consume && n_cal_fin;

            case (r_seq)
                SEQ_RUN: begin
                    if (w_consume) begin
                        r_mode     <= n_mode;
                        r_elapsed  <= n_elapsed;
                        r_count    <= n_count;
                        r_sum_near <= n_sum_near;
                        r_sum_far  <= n_sum_far;
                        if (n_cal_fin) begin
                            r_seq <= SEQ_CAL;
                        end
                    end
                end
                SEQ_CAL: begin
                    if (w_cal_done) begin
                        r_base_near <= w_cal_near;
                        r_base_far  <= w_cal_far;
                        r_tol       <= w_cal_tol;
                        r_seq       <= SEQ_EMIT;
                    end
                end
                SEQ_EMIT: begin
                    if (w_emit) begin
                        r_seq <= SEQ_RUN;
                    end
                end
                default: begin
                    r_seq <= SEQ_RUN;
                end
            endcase
        end

        // payload registers
        if (w_accept) begin
            r_near   <= i_near_distance;
            r_far    <= i_far_distance;
            r_door   <= i_door_closed;
            r_motion <= i_motion_seen;
        end
        if (w_out_load) begin
            r_out_mode    <= w_res_mode;
            r_out_event   <= w_res_event;
            r_out_passage <= w_res_passage;
            r_out_ind     <= (w_res_mode inside {[MODE_DETECT:MODE_DONE]});
            r_out_poll    <= poll_for_mode(w_res_mode);
            r_out_tol     <= r_tol;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_mode_now            = r_out_mode;
    assign o_event_code          = r_out_event;
    assign o_passage_ms          = r_out_passage;
    assign o_indicator_on        = r_out_ind;
    assign o_poll_interval_ms    = r_out_poll;
    assign o_threshold_tolerance = r_out_tol;

    // the calibration unit only finishes while the sequencer waits for it
    `TBP_ASSERT_IMP(a_cal_done_in_cal, i_clk, i_rst_n, w_cal_done, r_seq == SEQ_CAL)

    // a passage time goes out only with an entrance or exit event
    `TBP_ASSERT_IMP(a_passage_event, i_clk, i_rst_n, o_valid && (o_passage_ms != '0), (o_event_code == EV_ENTRANCE) || (o_event_code == EV_EXIT))

    // calibration start is followed by a stalled input side
    `TBP_ASSERT_NXT(a_cal_stalls, i_clk, i_rst_n, r_cal_start, !w_consume && (r_seq == SEQ_CAL))

endmodule
